FILE: sv/wpid_pkg.sv
package wpid_pkg;

   localparam int OFFSET_W   = 32;
   localparam int GAIN_W     = 32;
   localparam int WUSED_W    = 7;
   localparam int LIMIT_W    = 31;
   localparam int INTEG_W    = 48;
   localparam int DERIV_W    = 33;
   localparam int PROD_W     = 65;
   localparam int ACC_W      = 82;
   localparam int FRAC_W     = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_USED    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_MAX_CORRECTION = 3'd4;

   localparam logic                  KIND_SAMPLE = 1'b0;
   localparam logic                  KIND_CLEAR  = 1'b1;

   localparam logic signed [GAIN_W-1:0]  GAIN_RESET      = 32'sd0;
   localparam logic [WUSED_W-1:0]        WUSED_RESET     = 7'd8;
   localparam logic [LIMIT_W-1:0]        LIMIT_RESET     = 31'd500000;
   localparam logic signed [INTEG_W-1:0] INTEG_MAX       = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN       = {1'b1, {(INTEG_W-1){1'b0}}};

   typedef struct packed {
      logic                        kind;
      logic signed [OFFSET_W-1:0]  offset_ns;
   } req_type;

   typedef struct packed {
      logic signed [OFFSET_W-1:0]  correction_ppb;
      logic                        locked;
      logic [31:0]                 sample_count;
      logic signed [INTEG_W-1:0]   integral_value;
   } rsp_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0]    gain_p;
      logic signed [GAIN_W-1:0]    gain_i;
      logic signed [GAIN_W-1:0]    gain_d;
      logic signed [OFFSET_W-1:0]  err;
      logic signed [DERIV_W-1:0]   deriv;
      logic signed [INTEG_W-1:0]   integ;
      logic [LIMIT_W-1:0]          limit;
   } pid_in_type;

endpackage

FILE: sv/wpid_ram.sv
module wpid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/wpid_div.sv
module wpid_div
   import wpid_pkg::*;
#(
   parameter int SUM_W = 38,
   parameter int DEN_W = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [SUM_W-1:0]    dividend,
   input  logic [DEN_W-1:0]           divisor,
   output logic                       done,
   output logic signed [OFFSET_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic                      busy_ff;
   logic                      done_ff;
   logic                      neg_ff;
   logic [STEP_W-1:0]         step_ff;
   logic [DEN_W-1:0]          rem_ff;
   logic [SUM_W-1:0]          q_ff;
   logic [DEN_W-1:0]          den_ff;
   logic signed [OFFSET_W-1:0] quot_ff;

   logic [SUM_W-1:0] mag;
   logic [DEN_W:0]   shifted;
   logic             ge;
   logic [DEN_W-1:0] rem_in;
   logic [SUM_W-1:0] q_in;
   logic [SUM_W-1:0] q_signed;

   always_comb begin
      mag      = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      shifted  = {rem_ff, q_ff[SUM_W-1]};
      ge       = shifted >= {1'b0, den_ff};
      rem_in   = ge ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
      q_in     = {q_ff[SUM_W-2:0], ge};
      q_signed = neg_ff ? (~q_in + 1'b1) : q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= '0;
            q_ff    <= mag;
            den_ff  <= divisor;
            neg_ff  <= dividend[SUM_W-1];
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            q_ff    <= q_in;
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               quot_ff <= q_signed[OFFSET_W-1:0];
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

FILE: sv/wpid_pid.sv
module wpid_pid
   import wpid_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  pid_in_type                 pid_in,
   output logic                       done,
   output logic signed [OFFSET_W-1:0] correction
);

   logic                       busy_ff;
   logic                       done_ff;
   logic [2:0]                 cnt_ff;
   logic                       pvalid_ff;
   logic                       pshift_ff;
   logic signed [PROD_W-1:0]   p_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [OFFSET_W-1:0] corr_ff;

   logic signed [GAIN_W-1:0]  op_a;
   logic signed [DERIV_W-1:0] op_b;
   logic                      op_shift;
   logic signed [PROD_W-1:0]  p_in;
   logic signed [ACC_W-1:0]   p_ext;
   logic signed [ACC_W-1:0]   addend;
   logic signed [ACC_W-1:0]   shr;
   logic signed [ACC_W-1:0]   lim_ext;
   logic signed [OFFSET_W-1:0] corr_in;

   always_comb begin
      op_a     = '0;
      op_b     = '0;
      op_shift = 1'b0;
      case (cnt_ff)
         3'd0: begin
            op_a = pid_in.gain_p;
            op_b = {pid_in.err[OFFSET_W-1], pid_in.err};
         end
         3'd1: begin
            op_a = pid_in.gain_d;
            op_b = pid_in.deriv;
         end
         3'd2: begin
            op_a = pid_in.gain_i;
            op_b = {{(DERIV_W-FRAC_W){1'b0}}, pid_in.integ[FRAC_W-1:0]};
         end
         3'd3: begin
            op_a     = pid_in.gain_i;
            op_b     = {pid_in.integ[INTEG_W-1], pid_in.integ[INTEG_W-1:FRAC_W]};
            op_shift = 1'b1;
         end
         default: begin
            op_a = '0;
         end
      endcase
      p_in    = op_a * op_b;
      p_ext   = {{(ACC_W-PROD_W){p_ff[PROD_W-1]}}, p_ff};
      addend  = pshift_ff ? {p_ext[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}} : p_ext;
      shr     = acc_ff >>> FRAC_W;
      lim_ext = {{(ACC_W-LIMIT_W){1'b0}}, pid_in.limit};
      if (shr > lim_ext) begin
         corr_in = {1'b0, pid_in.limit};
      end else if (shr < -lim_ext) begin
         corr_in = -$signed({1'b0, pid_in.limit});
      end else begin
         corr_in = shr[OFFSET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
         pvalid_ff <= 1'b0;
      end else begin
         done_ff   <= 1'b0;
         pvalid_ff <= busy_ff && (cnt_ff <= 3'd3);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 3'd5) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               corr_ff <= corr_in;
            end
         end
         if (pvalid_ff) begin
            acc_ff <= acc_ff + addend;
         end
      end
      p_ff      <= p_in;
      pshift_ff <= op_shift;
   end

   assign done       = done_ff;
   assign correction = corr_ff;

endmodule

FILE: sv/windowed_pid_rate_corrector.sv
// Sample beat: the window average is formed by the bit-serial window-average divider,
// one quotient bit per cycle. Clear beat: goes straight to posting its result.
// One beat in work at a time; the next is taken the cycle after the result is posted.
// A finished result waits in the output register while the next beat is accepted.
// Reset (synchronous): registers to defaults, window state emptied; the window
// RAM is not cleared, entries are only used after being written.
module windowed_pid_rate_corrector
   import wpid_pkg::*;
#(
   parameter int WINDOW_MAX = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int SLOT_W = $clog2(WINDOW_MAX);
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W  = OFFSET_W + SLOT_W;
   localparam logic [CNT_W-1:0] WIN_LEN_RESET =
      (int'(WUSED_RESET) > WINDOW_MAX) ? CNT_W'(WINDOW_MAX) : CNT_W'(WUSED_RESET);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_UPDATE, S_DIV_GO, S_DIV_WAIT,
      S_INTEG, S_PID_GO, S_PID_WAIT, S_FINISH
   } state_type;

   // configuration
   logic signed [GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [WUSED_W-1:0]       window_used_ff;
   logic [LIMIT_W-1:0]       max_corr_ff;
   logic [REG_IDX_W-1:0]     csr_idx;
   logic                     csr_wr;

   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= GAIN_RESET;
         gain_i_ff      <= GAIN_RESET;
         gain_d_ff      <= GAIN_RESET;
         window_used_ff <= WUSED_RESET;
         max_corr_ff    <= LIMIT_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_GAIN_P:         gain_p_ff      <= csr_pwdata;
            REG_GAIN_I:         gain_i_ff      <= csr_pwdata;
            REG_GAIN_D:         gain_d_ff      <= csr_pwdata;
            REG_WINDOW_USED:    window_used_ff <= csr_pwdata[WUSED_W-1:0];
            REG_MAX_CORRECTION: max_corr_ff    <= csr_pwdata[LIMIT_W-1:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_GAIN_P:         csr_prdata = gain_p_ff;
         REG_GAIN_I:         csr_prdata = gain_i_ff;
         REG_GAIN_D:         csr_prdata = gain_d_ff;
         REG_WINDOW_USED:    csr_prdata = {{(CSR_DATA_W-WUSED_W){1'b0}}, window_used_ff};
         REG_MAX_CORRECTION: csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, max_corr_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // servo state
   state_type                  state_ff;
   logic [CNT_W-1:0]           win_len_ff;
   logic [CNT_W-1:0]           fill_ff;
   logic [SLOT_W-1:0]          write_slot_ff;
   logic [SLOT_W-1:0]          slot_ff;
   logic signed [OFFSET_W-1:0] x_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [INTEG_W-1:0]  integ_ff;
   logic signed [OFFSET_W-1:0] prev_ff;
   logic signed [OFFSET_W-1:0] err_ff;
   logic signed [DERIV_W-1:0]  deriv_ff;
   logic signed [OFFSET_W-1:0] corr_ff;
   logic [31:0]                samples_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff;

   logic [CNT_W-1:0]           win_len_in;
   logic [SLOT_W-1:0]          slot_in;
   logic                       full;
   logic [OFFSET_W-1:0]        old_x;
   logic signed [SUM_W-1:0]    sum_in;
   logic [CNT_W-1:0]           slot_next;
   logic [SLOT_W-1:0]          write_slot_in;
   logic signed [OFFSET_W-1:0] div_q;
   logic                       div_done;
   logic signed [INTEG_W:0]    integ_wide;
   logic signed [INTEG_W-1:0]  integ_in;
   logic signed [DERIV_W-1:0]  deriv_in;
   logic [OFFSET_W-1:0]        mag;
   logic [OFFSET_W+3:0]        mag10;
   logic                       locked_in;
   logic                       rsp_free;
   logic                       pid_done;
   logic signed [OFFSET_W-1:0] pid_corr;
   pid_in_type                 pid_in;

   always_comb begin
      if (window_used_ff == '0) begin
         win_len_in = CNT_W'(1);
      end else if (int'(window_used_ff) > WINDOW_MAX) begin
         win_len_in = CNT_W'(WINDOW_MAX);
      end else begin
         win_len_in = CNT_W'(window_used_ff);
      end
      slot_in       = (CNT_W'(write_slot_ff) >= win_len_ff) ? '0 : write_slot_ff;
      full          = fill_ff >= win_len_ff;
      sum_in        = sum_ff + {{SLOT_W{x_ff[OFFSET_W-1]}}, x_ff}
                      - (full ? {{SLOT_W{old_x[OFFSET_W-1]}}, old_x} : '0);
      slot_next     = CNT_W'(slot_ff) + 1'b1;
      write_slot_in = (slot_next >= win_len_ff) ? '0 : slot_next[SLOT_W-1:0];
      integ_wide    = {integ_ff[INTEG_W-1], integ_ff}
                      + {{(INTEG_W-OFFSET_W+1){div_q[OFFSET_W-1]}}, div_q};
      if (integ_wide > $signed({INTEG_MAX[INTEG_W-1], INTEG_MAX})) begin
         integ_in = INTEG_MAX;
      end else if (integ_wide < $signed({INTEG_MIN[INTEG_W-1], INTEG_MIN})) begin
         integ_in = INTEG_MIN;
      end else begin
         integ_in = integ_wide[INTEG_W-1:0];
      end
      deriv_in  = {div_q[OFFSET_W-1], div_q} - {prev_ff[OFFSET_W-1], prev_ff};
      mag       = corr_ff[OFFSET_W-1] ? (~corr_ff + 1'b1) : corr_ff;
      mag10     = {mag, 3'b000} + {2'b00, mag, 1'b0};
      locked_in = full && (mag10 < {{(OFFSET_W+4-LIMIT_W){1'b0}}, max_corr_ff});
      rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         win_len_ff    <= WIN_LEN_RESET;
         fill_ff       <= '0;
         write_slot_ff <= '0;
         sum_ff        <= '0;
         integ_ff      <= '0;
         prev_ff       <= '0;
         corr_ff       <= '0;
         samples_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (state_ff == S_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_data.kind == KIND_CLEAR) begin
                     win_len_ff    <= win_len_in;
                     fill_ff       <= '0;
                     write_slot_ff <= '0;
                     sum_ff        <= '0;
                     integ_ff      <= '0;
                     prev_ff       <= '0;
                     corr_ff       <= '0;
                     samples_ff    <= '0;
                     state_ff      <= S_FINISH;
                  end else begin
                     x_ff     <= req_data.offset_ns;
                     slot_ff  <= slot_in;
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               sum_ff        <= sum_in;
               fill_ff       <= full ? fill_ff : fill_ff + 1'b1;
               write_slot_ff <= write_slot_in;
               samples_ff    <= samples_ff + 1'b1;
               state_ff      <= S_DIV_GO;
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  state_ff <= S_INTEG;
               end
            end
            S_INTEG: begin
               err_ff   <= div_q;
               prev_ff  <= div_q;
               deriv_ff <= deriv_in;
               integ_ff <= integ_in;
               state_ff <= S_PID_GO;
            end
            S_PID_GO: begin
               state_ff <= S_PID_WAIT;
            end
            S_PID_WAIT: begin
               if (pid_done) begin
                  corr_ff  <= pid_corr;
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (rsp_free) begin
                  rsp_data_ff.correction_ppb  <= corr_ff;
                  rsp_data_ff.locked          <= locked_in;
                  rsp_data_ff.sample_count    <= samples_ff;
                  rsp_data_ff.integral_value  <= integ_ff;
                  state_ff                    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   wpid_ram #(
      .WIDTH(OFFSET_W),
      .DEPTH(WINDOW_MAX)
   ) u_window (
      .clock  (clock),
      .wr_en  (state_ff == S_UPDATE),
      .wr_addr(slot_ff),
      .wr_data(x_ff),
      .rd_addr(slot_ff),
      .rd_data(old_x)
   );

   wpid_div #(
      .SUM_W(SUM_W),
      .DEN_W(CNT_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == S_DIV_GO),
      .dividend(sum_ff),
      .divisor (fill_ff),
      .done    (div_done),
      .quotient(div_q)
   );

   always_comb begin
      pid_in.gain_p = gain_p_ff;
      pid_in.gain_i = gain_i_ff;
      pid_in.gain_d = gain_d_ff;
      pid_in.err    = err_ff;
      pid_in.deriv  = deriv_ff;
      pid_in.integ  = integ_ff;
      pid_in.limit  = max_corr_ff;
   end

   wpid_pid u_pid (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == S_PID_GO),
      .pid_in    (pid_in),
      .done      (pid_done),
      .correction(pid_corr)
   );

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= win_len_ff)
      else $error("fill count exceeds window length");

   a_slot_bounded: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(write_slot_ff) < win_len_ff)
      else $error("write slot outside window");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_WAIT) |-> (fill_ff != '0))
      else $error("window average with empty window");

   a_sample_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |=> (samples_ff == $past(samples_ff) + 32'd1))
      else $error("sample count not advanced");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import wpid_pkg::*;
;

   localparam int WIN_DEPTH   = 64;
   localparam int QUIET_LIMIT = 2000;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   windowed_pid_rate_corrector #(
      .WINDOW_MAX(WIN_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // servo register copies
   logic signed [GAIN_W-1:0] kp, ki, kd;
   logic [WUSED_W-1:0]       wlen_cfg;
   logic [LIMIT_W-1:0]       corr_limit;

   // servo state
   logic signed [OFFSET_W-1:0] slot_mem [WIN_DEPTH];
   int unsigned fill_n, wr_pos, len_held;
   longint      win_total, integ_acc, prev_err, corr_held;
   logic [31:0] seen_n;

   rsp_type pending_rsp [$];
   int      mismatches = 0;
   int      beats_seen = 0;
   bit      gaps_on    = 1'b1;

   function automatic void clear_servo();
      fill_n    = 0;
      wr_pos    = 0;
      win_total = 0;
      integ_acc = 0;
      prev_err  = 0;
      corr_held = 0;
      seen_n    = '0;
      if (wlen_cfg == 0) len_held = 1;
      else if (wlen_cfg > WIN_DEPTH) len_held = WIN_DEPTH;
      else len_held = wlen_cfg;
   endfunction

   function automatic void reset_servo();
      kp         = GAIN_RESET;
      ki         = GAIN_RESET;
      kd         = GAIN_RESET;
      wlen_cfg   = WUSED_RESET;
      corr_limit = LIMIT_RESET;
      clear_servo();
   endfunction

   function automatic rsp_type servo_step(req_type r);
      logic signed [81:0] wkp, wki, wkd, werr, wint, wder, wsum, wlim;
      longint xs, avg, der, mag;
      rsp_type o;
      if (r.kind == KIND_CLEAR) begin
         clear_servo();
      end else begin
         xs = $signed(r.offset_ns);
         if (wr_pos >= len_held || wr_pos >= WIN_DEPTH) wr_pos = 0;
         if (fill_n >= len_held) win_total = win_total - slot_mem[wr_pos];
         else fill_n++;
         slot_mem[wr_pos] = r.offset_ns;
         win_total = win_total + xs;
         wr_pos++;
         if (wr_pos >= len_held) wr_pos = 0;
         seen_n = seen_n + 32'd1;
         avg = win_total / longint'(fill_n);
         integ_acc = integ_acc + avg;
         if (integ_acc > INTEG_MAX) integ_acc = INTEG_MAX;
         if (integ_acc < INTEG_MIN) integ_acc = INTEG_MIN;
         der = avg - prev_err;
         prev_err = avg;
         wkp  = kp;
         wki  = ki;
         wkd  = kd;
         werr = avg;
         wint = integ_acc;
         wder = der;
         wlim = corr_limit;
         wsum = wkp * werr + wki * wint + wkd * wder;
         wsum = wsum >>> FRAC_W;
         if (wsum > wlim) wsum = wlim;
         if (wsum < -wlim) wsum = -wlim;
         corr_held = wsum;
      end
      mag = (corr_held < 0) ? -corr_held : corr_held;
      o.correction_ppb = corr_held[31:0];
      o.locked         = (fill_n >= len_held) && (mag * 10 < longint'(corr_limit));
      o.sample_count   = seen_n;
      o.integral_value = integ_acc[INTEG_W-1:0];
      return o;
   endfunction

   task automatic send_beat(input logic kind, input logic [31:0] offset);
      req_type r;
      r.kind      = kind;
      r.offset_ns = offset;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      pending_rsp.insert(pending_rsp.size(), servo_step(r));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_GAIN_P:         kp = value;
         REG_GAIN_I:         ki = value;
         REG_GAIN_D:         kd = value;
         REG_WINDOW_USED:    wlen_cfg = value[WUSED_W-1:0];
         REG_MAX_CORRECTION: corr_limit = value[LIMIT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_servo(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                            input logic [31:0] w, input logic [31:0] lim);
      csr_write(REG_GAIN_P, p);
      csr_write(REG_GAIN_I, i);
      csr_write(REG_GAIN_D, d);
      csr_write(REG_WINDOW_USED, w);
      csr_write(REG_MAX_CORRECTION, lim);
   endtask

   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatches++;
      if (mismatches <= 10)
         $display("beat %0d %s: expected %0d, got %0d", beats_seen, what, want, got);
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected beat, correction_ppb", 0, rsp_data.correction_ppb);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.correction_ppb !== want.correction_ppb)
               report_mismatch("correction_ppb", want.correction_ppb,
                               rsp_data.correction_ppb);
            if (rsp_data.locked !== want.locked)
               report_mismatch("locked", want.locked, rsp_data.locked);
            if (rsp_data.sample_count !== want.sample_count)
               report_mismatch("sample_count", want.sample_count, rsp_data.sample_count);
            if (rsp_data.integral_value !== want.integral_value)
               report_mismatch("integral_value", want.integral_value,
                               rsp_data.integral_value);
         end
         beats_seen++;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) quiet = 0;
         else quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1, 2:    return $urandom_range(0, 1 << 18) - (1 << 17);
         3:       return $urandom_range(0, 1 << 24) - (1 << 23);
         4:       return $urandom;
         default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_window();
      case ($urandom_range(0, 8))
         6:       return WIN_DEPTH;
         7:       return $urandom_range(17, 63);
         8:       return $urandom_range(0, 127);
         default: return $urandom_range(1, 16);
      endcase
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(0, 6))
         0:       return {1'b0, LIMIT_RESET};
         1:       return $urandom_range(0, 1000);
         2:       return $urandom & 32'h7fff_ffff;
         3:       return 32'h7fff_ffff;
         4:       return 32'd0;
         default: return $urandom_range(1000, 5000000);
      endcase
   endfunction

   function automatic logic [31:0] pick_offset();
      case ($urandom_range(0, 9))
         4, 5:    return $urandom;
         6:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         7, 8:    return $urandom_range(0, 1 << 21) - (1 << 20);
         9:       return $urandom_range(0, 2) - 1;
         default: return $urandom_range(0, 4000) - 2000;
      endcase
   endfunction

   // reset settings: zero gains, window of 8, wraps once
   task automatic test_defaults();
      send_beat(KIND_SAMPLE, 32'd0);
      send_beat(KIND_SAMPLE, 32'h7fff_ffff);
      send_beat(KIND_SAMPLE, 32'h8000_0000);
      send_beat(KIND_SAMPLE, 32'hffff_ffff);
      send_beat(KIND_SAMPLE, 32'd1);
      send_beat(KIND_SAMPLE, 32'd12345);
      send_beat(KIND_SAMPLE, -32'sd54321);
      send_beat(KIND_SAMPLE, 32'h7fff_ffff);
      send_beat(KIND_SAMPLE, 32'h8000_0000);
   endtask

   task automatic test_config_extremes();
      // window 0 runs as 1, unity P gain, widest clamp
      drain();
      set_servo(32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h7fff_ffff);
      send_beat(KIND_CLEAR, 32'hdead_beef);
      send_beat(KIND_SAMPLE, 32'h7fff_ffff);
      send_beat(KIND_SAMPLE, 32'h8000_0000);
      send_beat(KIND_SAMPLE, 32'd100);
      // new window length only after a clear
      drain();
      csr_write(REG_WINDOW_USED, 32'd3);
      send_beat(KIND_SAMPLE, -32'sd100);
      send_beat(KIND_SAMPLE, 32'd250);
      send_beat(KIND_CLEAR, 32'd0);
      send_beat(KIND_SAMPLE, 32'd30);
      send_beat(KIND_SAMPLE, 32'd60);
      send_beat(KIND_SAMPLE, 32'd90);
      send_beat(KIND_SAMPLE, -32'sd300);
      // most negative gains, oversized window, zero clamp
      drain();
      set_servo(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd127, 32'd0);
      send_beat(KIND_CLEAR, 32'hffff_ffff);
      send_beat(KIND_SAMPLE, 32'd5);
      send_beat(KIND_SAMPLE, -32'sd5);
      // most positive gains, small clamp
      drain();
      set_servo(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd127, 32'd1000);
      send_beat(KIND_SAMPLE, 32'd1);
      send_beat(KIND_SAMPLE, 32'hffff_ffff);
   endtask

   task automatic test_random_phases(input int target);
      int sent;
      int span;
      sent = 0;
      while (sent < target) begin
         drain();
         gaps_on = (sent < target - 300) && ($urandom_range(0, 3) != 0);
         set_servo(pick_gain(), pick_gain(), pick_gain(), pick_window(), pick_limit());
         if ($urandom_range(0, 3) != 0) send_beat(KIND_CLEAR, $urandom);
         span = $urandom_range(40, 160);
         repeat (span) begin
            if ($urandom_range(0, 24) == 0) send_beat(KIND_CLEAR, $urandom);
            else send_beat(KIND_SAMPLE, pick_offset());
         end
         sent += span;
      end
   endtask

   initial begin
      reset_servo();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_defaults();
      test_config_extremes();
      test_random_phases(1600);
      drain();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/wpid_pkg.sv
sv/wpid_ram.sv
sv/wpid_div.sv
sv/wpid_pid.sv
sv/windowed_pid_rate_corrector.sv
sim/tb_top.sv
